// File: rtl/core/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg
// shared types and constants for the inverted page table
// ----------------------------------------------------------------------------
package ipt_pkg;

   localparam int TABLE_SIZE = 16;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int PID_W      = 8;
   localparam int KEY_W      = 40;
   localparam int COUNT_W    = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(TABLE_SIZE - 1);

   // operation codes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // result status codes
   localparam logic ST_OK   = 1'b0;
   localparam logic ST_MISS = 1'b1;

   typedef struct packed {
      logic [1:0]       op;
      logic [PID_W-1:0] process_id;
      logic [KEY_W-1:0] page_key;
      logic             is_write;
   } ipt_req_type;

   typedef struct packed {
      logic               status;
      logic [COUNT_W-1:0] writeback_count;
   } ipt_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLY
   } ipt_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture request, rewind scan
      logic step;   // act on the current frame, advance
   } ipt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_ok;  // request carries a defined operation
      logic found;  // lookup hit or insert slot at the current frame
      logic last;   // current frame is the last one
   } ipt_stat_type;

endpackage

// File: rtl/core/inverted_page_table.sv
// ----------------------------------------------------------------------------
// inverted_page_table
// inverted page table with lookup / insert / per-process flush
// ----------------------------------------------------------------------------
//
//  channel   ports                        handshake
//  --------  ---------------------------  -----------------------------------
//  request   start, busy, req_data        taken when start && !busy
//  result    rsp_valid, rsp_data          one-cycle strobe, cannot be held off
//
//  a request is accepted in ST_IDLE, scans one to TABLE_SIZE frames in ST_SCAN
//  and replies in ST_REPLY
//  the scan visits one frame per cycle through a single compare unit; lookup
//  stops at the first match, insert at the first free frame, flush always walks every frame
//  an undefined op code skips the scan and replies with a miss
//  reset empties every frame and clears all write marks
//  busy stays high from the cycle after acceptance through the reply cycle; nothing stalls
//
module inverted_page_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ipt_pkg::ipt_req_type req_data,
   output logic                 rsp_valid,
   output ipt_pkg::ipt_rsp_type rsp_data
);

   ipt_pkg::ipt_cmd_type  cmd;
   ipt_pkg::ipt_stat_type stat;

   // sequencer
   ipt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // frame store and scan datapath
   ipt_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // an accepted request makes the block busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // reply strobe lasts one cycle only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("reply strobe longer than one cycle");

   // the reply cycle still counts as busy, so no request overlaps it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("reply while idle");

   // a nonzero writeback count only comes with a successful flush
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.writeback_count != '0)) |-> (rsp_data.status == ipt_pkg::ST_OK))
      else $error("writeback count on a failed request");

endmodule

// File: rtl/core/ipt_ctrl.sv
// ----------------------------------------------------------------------------
// ipt_ctrl
// request sequencer: accept, frame scan, one-cycle reply
// ----------------------------------------------------------------------------
module ipt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ipt_pkg::ipt_stat_type stat,
   output ipt_pkg::ipt_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   ipt_pkg::ipt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = ipt_pkg::ST_SCAN;
            end
         end
         ipt_pkg::ST_SCAN: begin
            if (!stat.op_ok || stat.found || stat.last) begin
               state_in = ipt_pkg::ST_REPLY;
            end
         end
         ipt_pkg::ST_REPLY: begin
            state_in = ipt_pkg::ST_IDLE;
         end
         default: begin
            state_in = ipt_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ipt_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ipt_pkg::ST_SCAN: begin
            cmd.step = stat.op_ok;
         end
         ipt_pkg::ST_REPLY: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/core/ipt_dp.sv
// ----------------------------------------------------------------------------
// ipt_dp
// frame store, scan index and result registers
// ----------------------------------------------------------------------------
module ipt_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ipt_pkg::ipt_req_type  req_data,
   input  ipt_pkg::ipt_cmd_type  cmd,
   output ipt_pkg::ipt_stat_type stat,
   output ipt_pkg::ipt_rsp_type  rsp_data
);

   ipt_pkg::ipt_req_type                req_ff;
   logic [ipt_pkg::IDX_W-1:0]           idx_ff, idx_in;
   logic [ipt_pkg::TABLE_SIZE-1:0]      valid_ff, valid_in;
   logic [ipt_pkg::TABLE_SIZE-1:0]      dirty_ff, dirty_in;
   logic                                status_ff, status_in;
   logic [ipt_pkg::COUNT_W-1:0]         count_ff, count_in;

   // owner and page key, read only behind a valid bit
   logic [ipt_pkg::PID_W-1:0] owner_ff [ipt_pkg::TABLE_SIZE];
   logic [ipt_pkg::KEY_W-1:0] page_ff  [ipt_pkg::TABLE_SIZE];

   // registered read of the frame under the scan index
   logic [ipt_pkg::PID_W-1:0] owner_rd_ff;
   logic [ipt_pkg::KEY_W-1:0] page_rd_ff;

   logic owner_hit, entry_hit, is_lookup, is_insert, is_flush;
   logic do_mark, do_fill, do_free;

   assign is_lookup = (req_ff.op == ipt_pkg::OP_LOOKUP);
   assign is_insert = (req_ff.op == ipt_pkg::OP_INSERT);
   assign is_flush  = (req_ff.op == ipt_pkg::OP_FLUSH);

   assign owner_hit = valid_ff[idx_ff] && (owner_rd_ff == req_ff.process_id);
   assign entry_hit = owner_hit && (page_rd_ff == req_ff.page_key);

   assign do_mark = cmd.step && is_lookup && entry_hit;
   assign do_fill = cmd.step && is_insert && !valid_ff[idx_ff];
   assign do_free = cmd.step && is_flush && owner_hit;

   assign stat.op_ok = is_lookup || is_insert || is_flush;
   assign stat.found = (is_lookup && entry_hit) || (is_insert && !valid_ff[idx_ff]);
   assign stat.last  = (idx_ff == ipt_pkg::IDX_LAST);

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      status_in = status_ff;
      count_in  = count_ff;
      if (cmd.load) begin
         idx_in    = '0;
         count_in  = '0;
         status_in = (req_data.op == ipt_pkg::OP_FLUSH) ? ipt_pkg::ST_OK : ipt_pkg::ST_MISS;
      end else if (cmd.step) begin
         idx_in = idx_ff + 1'b1;
         if (do_mark) begin
            dirty_in[idx_ff] = req_ff.is_write;
            status_in        = ipt_pkg::ST_OK;
         end
         if (do_fill) begin
            valid_in[idx_ff] = 1'b1;
            dirty_in[idx_ff] = req_ff.is_write;
            status_in        = ipt_pkg::ST_OK;
         end
         if (do_free) begin
            valid_in[idx_ff] = 1'b0;
            dirty_in[idx_ff] = 1'b0;
            if (dirty_ff[idx_ff] && (count_ff != ipt_pkg::COUNT_MAX)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      count_ff  <= count_in;
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // write on fill; read follows the next scan index so the data lines up
   // with idx_ff in the following cycle
   always_ff @(posedge clock) begin
      if (do_fill) begin
         owner_ff[idx_ff] <= req_ff.process_id;
         page_ff[idx_ff]  <= req_ff.page_key;
      end
      owner_rd_ff <= owner_ff[idx_in];
      page_rd_ff  <= page_ff[idx_in];
   end

   assign rsp_data.status          = status_ff;
   assign rsp_data.writeback_count = count_ff;

endmodule
